@@ rtl/line_plane_intersection_assert.svh @@
// Assertion macros for the line-plane intersection block.
// Included by the top level; depends on nothing else.
`ifndef LINE_PLANE_INTERSECTION_ASSERT_SVH
`define LINE_PLANE_INTERSECTION_ASSERT_SVH

// Same-cycle implication.
`define LPI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LPI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lpi_pkg.sv @@
// Shared constants for the line-plane intersection block.
// No dependencies.
package lpi_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_NORMAL_X  = 3'd0,
      REG_NORMAL_Y  = 3'd1,
      REG_NORMAL_Z  = 3'd2,
      REG_OFFSET    = 3'd3,
      REG_THRESHOLD = 3'd4
   } csr_index_type;

endpackage

@@ rtl/line_plane_intersection.sv @@
// Line-plane intersection pipeline, top level.
// Depends on lpi_pkg and line_plane_intersection_assert.svh.
//
// Usage: the plane n.x + w = 0 and the parallel threshold are written through the csr_
// port while the block is idle. A request on the req_ channel carries a segment start and
// end point; the block answers each request with one response on the rsp_ channel holding
// a hit flag and the intersection point, all in signed fixed point.
// The datapath is a fixed pipeline: six arithmetic stages (dot products, sums, magnitudes,
// split multiply, dividend assembly), one restoring-divider stage per dividend bit
// (3*COORD_WIDTH-FRAC_BITS+4 stages, 84 by default) and two output stages. One request is
// accepted every cycle while req_stall is low; the per-bit divider stages set the depth,
// not the rate.
// Each stage holds a valid bit and loads whenever it is empty or the stage after it moves,
// so bubbles close up and requests are still accepted while a response waits on a stall.
// When the receiver stalls and the pipeline is full, req_stall rises; nothing is lost or
// repeated. Reset clears all valid bits and loads the register reset values (normal and
// offset zero, threshold one).

`include "line_plane_intersection_assert.svh"

module line_plane_intersection
   import lpi_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y,
   output logic signed [COORD_WIDTH-1:0] rsp_point_z
);

   localparam int W   = COORD_WIDTH;
   localparam int PW  = 2 * W;                 // exact product
   localparam int VW  = 2 * W - FRAC_BITS + 2; // dot product sum
   localparam int NW  = VW + 1;                // numerator / denominator
   localparam int DMW = W + 1;                 // coordinate difference
   localparam int NL  = (NW + 1) / 2;          // low half of the numerator magnitude
   localparam int NH  = NW - NL;
   localparam int DW  = DMW + NW;              // dividend and quotient width
   localparam int QXW = (DW > 63) ? DW : 63;   // quotient width with room for the clamp
   localparam int SW  = QXW + 2;               // final sum
   localparam int TW  = (NW > W - 1) ? NW : W - 1;
   localparam int DV0 = 5;                     // stage index of the divider input
   localparam int NS  = DW + 8;                // pipeline stages

   // Configuration registers.
   logic signed [W-1:0] nrm_ff [3];
   logic signed [W-1:0] ofs_ff;
   logic [W-2:0]        thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) nrm_ff[i] <= '0;
         ofs_ff <= '0;
         thr_ff <= (W-1)'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_NORMAL_X:  nrm_ff[0] <= csr_wdata;
            REG_NORMAL_Y:  nrm_ff[1] <= csr_wdata;
            REG_NORMAL_Z:  nrm_ff[2] <= csr_wdata;
            REG_OFFSET:    ofs_ff <= csr_wdata;
            REG_THRESHOLD: thr_ff <= csr_wdata[W-2:0];
            default: ;
         endcase
      end
   end

   // Stage flow control: a stage loads when empty or when its successor moves.
   logic [NS-1:0] v_ff, v_in, en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) en[k] = !v_ff[k] || en[k+1];
      for (int k = 0; k < NS; k++) begin
         if (!en[k]) v_in[k] = v_ff[k];
         else if (k == 0) v_in[k] = req_valid;
         else v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= v_in;
   end

   assign req_stall = !en[0];

   logic signed [W-1:0] req_s [3];
   logic signed [W-1:0] req_e [3];
   always_comb begin
      req_s[0] = req_start_x; req_s[1] = req_start_y; req_s[2] = req_start_z;
      req_e[0] = req_end_x;   req_e[1] = req_end_y;   req_e[2] = req_end_z;
   end

   // Stage 0: the six exact products.
   logic signed [W-1:0]  s0_s_ff [3];
   logic signed [W-1:0]  s0_e_ff [3];
   logic signed [PW-1:0] s0_ps_ff [3];
   logic signed [PW-1:0] s0_pe_ff [3];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            s0_s_ff[i]  <= req_s[i];
            s0_e_ff[i]  <= req_e[i];
            s0_ps_ff[i] <= PW'(nrm_ff[i]) * PW'(req_s[i]);
            s0_pe_ff[i] <= PW'(nrm_ff[i]) * PW'(req_e[i]);
         end
      end
   end

   // Stage 1: floor each product to the binary point and sum.
   logic signed [W-1:0]  s1_s_ff [3];
   logic signed [W-1:0]  s1_e_ff [3];
   logic signed [VW-1:0] s1_v1_ff, s1_v2_ff;
   logic signed [VW-1:0] s1_v1_in, s1_v2_in;

   always_comb begin
      s1_v1_in = '0;
      s1_v2_in = '0;
      for (int i = 0; i < 3; i++) begin
         s1_v1_in = s1_v1_in + VW'(s0_ps_ff[i] >>> FRAC_BITS);
         s1_v2_in = s1_v2_in + VW'(s0_pe_ff[i] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_s_ff  <= s0_s_ff;
         s1_e_ff  <= s0_e_ff;
         s1_v1_ff <= s1_v1_in;
         s1_v2_ff <= s1_v2_in;
      end
   end

   // Stage 2: numerator, denominator and coordinate differences.
   logic signed [W-1:0]   s2_s_ff [3];
   logic signed [DMW-1:0] s2_diff_ff [3];
   logic signed [NW-1:0]  s2_num_ff, s2_den_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_s_ff   <= s1_s_ff;
         s2_num_ff <= NW'(s1_v1_ff) + NW'(ofs_ff);
         s2_den_ff <= NW'(s1_v1_ff) - NW'(s1_v2_ff);
         for (int i = 0; i < 3; i++)
            s2_diff_ff[i] <= DMW'(s1_e_ff[i]) - DMW'(s1_s_ff[i]);
      end
   end

   // Stage 3: magnitudes, result signs and the parallel test.
   logic signed [W-1:0] s3_s_ff [3];
   logic [DMW-1:0]      s3_dmag_ff [3];
   logic [2:0]          s3_neg_ff;
   logic [NW-1:0]       s3_nmag_ff, s3_dvs_ff;
   logic                s3_hit_ff;
   logic [NW-1:0]       s3_dvs_in;

   always_comb begin
      s3_dvs_in = s2_den_ff[NW-1] ? NW'(-s2_den_ff) : NW'(s2_den_ff);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_s_ff    <= s2_s_ff;
         s3_nmag_ff <= s2_num_ff[NW-1] ? NW'(-s2_num_ff) : NW'(s2_num_ff);
         s3_dvs_ff  <= s3_dvs_in;
         s3_hit_ff  <= !(s2_den_ff == '0 || TW'(s3_dvs_in) < TW'(thr_ff));
         for (int i = 0; i < 3; i++) begin
            s3_dmag_ff[i] <= s2_diff_ff[i][DMW-1] ? DMW'(-s2_diff_ff[i])
                                                  : DMW'(s2_diff_ff[i]);
            s3_neg_ff[i]  <= s2_diff_ff[i][DMW-1] ^ s2_num_ff[NW-1] ^ s2_den_ff[NW-1];
         end
      end
   end

   // Stage 4: difference times numerator, split into two narrower products.
   logic signed [W-1:0]   s4_s_ff [3];
   logic [DMW+NL-1:0]     s4_pl_ff [3];
   logic [DMW+NH-1:0]     s4_ph_ff [3];
   logic [2:0]            s4_neg_ff;
   logic [NW-1:0]         s4_dvs_ff;
   logic                  s4_hit_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_s_ff   <= s3_s_ff;
         s4_neg_ff <= s3_neg_ff;
         s4_dvs_ff <= s3_dvs_ff;
         s4_hit_ff <= s3_hit_ff;
         for (int i = 0; i < 3; i++) begin
            s4_pl_ff[i] <= (DMW+NL)'(s3_dmag_ff[i]) * (DMW+NL)'(s3_nmag_ff[NL-1:0]);
            s4_ph_ff[i] <= (DMW+NH)'(s3_dmag_ff[i]) * (DMW+NH)'(s3_nmag_ff[NW-1:NL]);
         end
      end
   end

   // Divider pipeline. Entry 0 is loaded by stage 5 with the assembled dividend;
   // entry j+1 holds the result of quotient bit j.
   logic [NW-1:0]       dv_rem_ff [DW+1][3];
   logic [DW-1:0]       dv_q_ff   [DW+1][3];
   logic [NW-1:0]       dv_dvs_ff [DW+1];
   logic signed [W-1:0] dv_s_ff   [DW+1][3];
   logic [2:0]          dv_neg_ff [DW+1];
   logic                dv_hit_ff [DW+1];

   always_ff @(posedge clock) begin
      if (en[DV0]) begin
         dv_dvs_ff[0] <= s4_dvs_ff;
         dv_neg_ff[0] <= s4_neg_ff;
         dv_hit_ff[0] <= s4_hit_ff;
         for (int i = 0; i < 3; i++) begin
            dv_s_ff[0][i]   <= s4_s_ff[i];
            dv_rem_ff[0][i] <= '0;
            dv_q_ff[0][i]   <= DW'(s4_pl_ff[i]) + (DW'(s4_ph_ff[i]) << NL);
         end
      end
   end

   for (genvar j = 0; j < DW; j++) begin : g_div
      logic [NW:0]   sh [3];
      logic [NW-1:0] rem_in [3];
      logic [2:0]    ge;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            sh[i]     = {dv_rem_ff[j][i], dv_q_ff[j][i][DW-1]};
            ge[i]     = sh[i] >= {1'b0, dv_dvs_ff[j]};
            rem_in[i] = ge[i] ? NW'(sh[i] - {1'b0, dv_dvs_ff[j]}) : NW'(sh[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (en[DV0+1+j]) begin
            dv_dvs_ff[j+1] <= dv_dvs_ff[j];
            dv_neg_ff[j+1] <= dv_neg_ff[j];
            dv_hit_ff[j+1] <= dv_hit_ff[j];
            for (int i = 0; i < 3; i++) begin
               dv_s_ff[j+1][i]   <= dv_s_ff[j][i];
               dv_rem_ff[j+1][i] <= rem_in[i];
               dv_q_ff[j+1][i]   <= {dv_q_ff[j][i][DW-2:0], ge[i]};
            end
         end
      end
   end

   // Clamp the quotient magnitude and apply its sign.
   localparam logic [QXW-1:0] QCLAMP = QXW'(1) << 62;

   logic signed [W-1:0]   f0_s_ff [3];
   logic signed [QXW:0]   f0_q_ff [3];
   logic                  f0_hit_ff;
   logic [QXW-1:0]        f0_qc [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f0_qc[i] = QXW'(dv_q_ff[DW][i]);
         if (f0_qc[i] > QCLAMP) f0_qc[i] = QCLAMP;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-2]) begin
         f0_hit_ff <= dv_hit_ff[DW];
         for (int i = 0; i < 3; i++) begin
            f0_s_ff[i] <= dv_s_ff[DW][i];
            f0_q_ff[i] <= dv_neg_ff[DW][i] ? -$signed({1'b0, f0_qc[i]})
                                           : $signed({1'b0, f0_qc[i]});
         end
      end
   end

   // Output stage: add the start point and saturate; a miss gives the zero point.
   logic signed [SW-1:0] f1_sum [3];
   logic signed [SW-1:0] smax, smin;
   logic signed [W-1:0]  f1_p [3];
   logic signed [W-1:0]  out_p_ff [3];
   logic                 out_hit_ff;

   always_comb begin
      smax = '0;
      smax[W-2:0] = '1;
      smin = ~smax;
      for (int i = 0; i < 3; i++) begin
         f1_sum[i] = SW'(f0_s_ff[i]) + SW'(f0_q_ff[i]);
         if (!f0_hit_ff) f1_p[i] = '0;
         else if (f1_sum[i] > smax) f1_p[i] = smax[W-1:0];
         else if (f1_sum[i] < smin) f1_p[i] = smin[W-1:0];
         else f1_p[i] = f1_sum[i][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         out_hit_ff <= f0_hit_ff;
         out_p_ff   <= f1_p;
      end
   end

   assign rsp_valid   = v_ff[NS-1];
   assign rsp_hit     = out_hit_ff;
   assign rsp_point_x = out_p_ff[0];
   assign rsp_point_y = out_p_ff[1];
   assign rsp_point_z = out_p_ff[2];

   // A miss always carries the zero point.
   `LPI_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0, "miss with nonzero point")
   // With the output register empty every stage can move, so requests flow in.
   `LPI_ASSERT_NOW(a_no_false_stall, clock, reset, !rsp_valid, !req_stall,
      "request stalled while output register is empty")
   // Reset empties the pipeline.
   `LPI_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && v_ff == '0,
      "pipeline not empty after reset")

endmodule
